/* design/eoo_pkg.sv */
package eoo_pkg;

   // Q1.16 smoothing coefficients
   localparam int unsigned FRAC_BITS   = 16;
   localparam int unsigned COEF_BITS   = FRAC_BITS + 1;
   localparam logic [COEF_BITS-1:0] COEF_ONE    = COEF_BITS'(65536);
   localparam logic [COEF_BITS-1:0] FORGET_PEAK = COEF_BITS'(655);
   localparam logic [COEF_BITS-1:0] FORGET_FLAT = COEF_BITS'(64881);
   localparam logic [COEF_BITS-1:0] ROUND_HALF  = COEF_BITS'(32768);

   // buffer length register
   localparam int unsigned LEN_BITS   = 13;
   localparam int unsigned POS_BITS   = 12;
   localparam logic [LEN_BITS-1:0] LEN_RESET  = LEN_BITS'(512);
   localparam logic [LEN_BITS-1:0] MAX_BUFFER = LEN_BITS'(4096);

   typedef struct packed {
      logic step;
      logic first;
   } mac_ctl_type;

endpackage

/* design/eoo_div.sv */
module eoo_div #(
   parameter int unsigned DIVIDEND_BITS = 16,
   parameter int unsigned DIVISOR_BITS  = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     busy,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int unsigned CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_BITS:0]    rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  div_ff, div_in;
   logic [DIVISOR_BITS:0]    trial;
   logic                     fits;

   // one restoring step per cycle: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff[DIVISOR_BITS-1:0], quo_ff[DIVIDEND_BITS-1]};
      fits   = (trial >= {1'b0, div_ff});
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      if (start) begin
         cnt_in = CNT_BITS'(DIVIDEND_BITS);
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
         rem_in = fits ? (trial - {1'b0, div_ff}) : trial;
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

/* design/eoo_mac.sv */
module eoo_mac #(
   parameter int unsigned OPND_BITS = 18
) (
   input  logic                              clock,
   input  eoo_pkg::mac_ctl_type              ctl,
   input  logic [eoo_pkg::COEF_BITS-1:0]     coef,
   input  logic [OPND_BITS-1:0]              operand,
   output logic [OPND_BITS+eoo_pkg::FRAC_BITS-1:0] acc
);

   localparam int unsigned ACC_BITS  = OPND_BITS + eoo_pkg::FRAC_BITS;
   localparam int unsigned PROD_BITS = OPND_BITS + eoo_pkg::COEF_BITS;

   logic [PROD_BITS-1:0] prod;
   logic [ACC_BITS-1:0]  base;
   logic [ACC_BITS-1:0]  acc_ff, acc_in;

   // shared multiplier; a first step starts the sum at the rounding bias
   always_comb begin
      prod   = PROD_BITS'(coef) * PROD_BITS'(operand);
      base   = ctl.first ? ACC_BITS'(eoo_pkg::ROUND_HALF) : acc_ff;
      acc_in = ctl.step ? (base + prod[ACC_BITS-1:0]) : acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* design/envelope_onset_offset_detector.sv */
// Envelope onset/offset detector.
// Input channel req_*: one envelope sample per beat, taken when req_valid is
// high and req_stall is low. Result channel rsp_*: one beat per sample with
// the onset/offset flags of the current buffer, the adaptive threshold (Q2.16),
// the running mean (Q0.16) and buffer_end on the last sample of a buffer.
// csr_we/csr_wdata write the buffer length; write it only while idle.
// Each sample goes through the bit-serial divider for the mean update (one
// quotient bit a cycle), then the mean step and two passes through the shared
// multiply-accumulate unit; no new sample is taken until it is through.
// req_stall is high while a sample is in work. A finished result sits in the
// output register; if the receiver stalls, the block holds the next result in
// its final step until the register frees, and takes no new sample meanwhile.
// Reset clears the sample window, mean, count, threshold, flags and buffer
// position, and sets the buffer length to 512.
module envelope_onset_offset_detector #(
   parameter int unsigned SAMPLE_BITS     = 16,
   parameter int unsigned MEAN_COUNT_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [SAMPLE_BITS-1:0]            req_envelope_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_onset_seen,
   output logic                              rsp_offset_seen,
   output logic [SAMPLE_BITS+1:0]            rsp_threshold_level,
   output logic [SAMPLE_BITS-1:0]            rsp_mean_level,
   output logic                              rsp_buffer_end,
   input  logic                              csr_we,
   input  logic [eoo_pkg::LEN_BITS-1:0]      csr_wdata
);

   localparam int unsigned THR_BITS = SAMPLE_BITS + 2;
   localparam int unsigned ACC_BITS = THR_BITS + eoo_pkg::FRAC_BITS;
   localparam int unsigned LB       = eoo_pkg::LEN_BITS;
   localparam int unsigned PB       = eoo_pkg::POS_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_MEAN,
      S_MUL_A,
      S_MUL_B,
      S_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   logic [SAMPLE_BITS-1:0]     oldest_ff, oldest_in;
   logic [SAMPLE_BITS-1:0]     middle_ff, middle_in;
   logic [SAMPLE_BITS-1:0]     newest_ff, newest_in;
   logic [MEAN_COUNT_BITS-1:0] count_ff, count_in;
   logic [SAMPLE_BITS-1:0]     mean_ff, mean_in;
   logic [THR_BITS-1:0]        thr_ff, thr_in;
   logic [PB-1:0]              pos_ff, pos_in;
   logic                       onset_ff, onset_in;
   logic                       offset_ff, offset_in;
   logic                       neg_ff, neg_in;
   logic [LB-1:0]              len_ff, len_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_onset_ff, rsp_onset_in;
   logic                       rsp_offset_ff, rsp_offset_in;
   logic [THR_BITS-1:0]        rsp_thr_ff, rsp_thr_in;
   logic [SAMPLE_BITS-1:0]     rsp_mean_ff, rsp_mean_in;
   logic                       rsp_end_ff, rsp_end_in;

   logic                       accept;
   logic                       div_start;
   logic                       div_busy;
   logic [SAMPLE_BITS-1:0]     div_mag;
   logic [SAMPLE_BITS-1:0]     quotient;
   eoo_pkg::mac_ctl_type       mac_ctl;
   logic [eoo_pkg::COEF_BITS-1:0] mac_coef;
   logic [THR_BITS-1:0]        mac_opnd;
   logic [ACC_BITS-1:0]        mac_acc;

   logic                       peak;
   logic [eoo_pkg::COEF_BITS-1:0] forget;
   logic [THR_BITS-1:0]        thr_new;
   logic [LB-1:0]              len_eff;
   logic                       last;
   logic                       rising, falling;
   logic                       onset_base, offset_base;
   logic                       out_free;

   eoo_div #(
      .DIVIDEND_BITS (SAMPLE_BITS),
      .DIVISOR_BITS  (MEAN_COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_mag),
      .divisor  (count_in),
      .busy     (div_busy),
      .quotient (quotient)
   );

   eoo_mac #(
      .OPND_BITS (THR_BITS)
   ) u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .coef    (mac_coef),
      .operand (mac_opnd),
      .acc     (mac_acc)
   );

   always_comb begin
      req_stall = (state_ff != S_IDLE);
      accept    = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;

      peak    = (middle_ff > oldest_ff) && (middle_ff > newest_ff);
      forget  = peak ? eoo_pkg::FORGET_PEAK : eoo_pkg::FORGET_FLAT;
      thr_new = mac_acc[ACC_BITS-1:eoo_pkg::FRAC_BITS];

      if (len_ff == '0) begin
         len_eff = LB'(1);
      end else if (len_ff > eoo_pkg::MAX_BUFFER) begin
         len_eff = eoo_pkg::MAX_BUFFER;
      end else begin
         len_eff = len_ff;
      end
      last = (({1'b0, pos_ff} + LB'(1)) >= len_eff);

      rising      = (oldest_ff < middle_ff) && (middle_ff < newest_ff);
      falling     = (oldest_ff > middle_ff) && (middle_ff > newest_ff);
      onset_base  = (pos_ff == '0) ? 1'b0 : onset_ff;
      offset_base = (pos_ff == '0) ? 1'b0 : offset_ff;

      state_in  = state_ff;
      oldest_in = oldest_ff;
      middle_in = middle_ff;
      newest_in = newest_ff;
      count_in  = count_ff;
      mean_in   = mean_ff;
      thr_in    = thr_ff;
      pos_in    = pos_ff;
      onset_in  = onset_ff;
      offset_in = offset_ff;
      neg_in    = neg_ff;
      len_in    = csr_we ? csr_wdata : len_ff;

      rsp_valid_in  = (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;
      rsp_onset_in  = rsp_onset_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_thr_in    = rsp_thr_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_end_in    = rsp_end_ff;

      div_start = 1'b0;
      div_mag   = (req_envelope_sample < mean_ff) ? (mean_ff - req_envelope_sample)
                                                  : (req_envelope_sample - mean_ff);
      mac_ctl   = '0;
      mac_coef  = forget;
      mac_opnd  = thr_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               oldest_in = middle_ff;
               middle_in = newest_ff;
               newest_in = req_envelope_sample;
               count_in  = (count_ff == '1) ? count_ff : (count_ff + MEAN_COUNT_BITS'(1));
               neg_in    = (req_envelope_sample < mean_ff);
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            mean_in  = neg_ff ? (mean_ff - quotient) : (mean_ff + quotient);
            state_in = S_MUL_A;
         end
         S_MUL_A: begin
            // pull toward four times the mean
            mac_ctl.step  = 1'b1;
            mac_ctl.first = 1'b1;
            mac_coef      = eoo_pkg::COEF_ONE - forget;
            mac_opnd      = {mean_ff, 2'b00};
            state_in      = S_MUL_B;
         end
         S_MUL_B: begin
            mac_ctl.step = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            // hold here until the output register can take the beat
            if (out_free) begin
               thr_in    = thr_new;
               onset_in  = onset_base;
               offset_in = offset_base;
               if (!onset_base && !offset_base) begin
                  onset_in  = rising && ({2'b00, middle_ff} > thr_new);
                  offset_in = falling && ({2'b00, middle_ff} < thr_new);
               end
               pos_in        = last ? '0 : (pos_ff + PB'(1));
               rsp_valid_in  = 1'b1;
               rsp_onset_in  = onset_in;
               rsp_offset_in = offset_in;
               rsp_thr_in    = thr_new;
               rsp_mean_in   = mean_ff;
               rsp_end_in    = last;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         middle_ff    <= '0;
         newest_ff    <= '0;
         count_ff     <= '0;
         mean_ff      <= '0;
         thr_ff       <= '0;
         pos_ff       <= '0;
         onset_ff     <= 1'b0;
         offset_ff    <= 1'b0;
         len_ff       <= eoo_pkg::LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         middle_ff    <= middle_in;
         newest_ff    <= newest_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         thr_ff       <= thr_in;
         pos_ff       <= pos_in;
         onset_ff     <= onset_in;
         offset_ff    <= offset_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff        <= neg_in;
      rsp_onset_ff  <= rsp_onset_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_thr_ff    <= rsp_thr_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_onset_seen      = rsp_onset_ff;
   assign rsp_offset_seen     = rsp_offset_ff;
   assign rsp_threshold_level = rsp_thr_ff;
   assign rsp_mean_level      = rsp_mean_ff;
   assign rsp_buffer_end      = rsp_end_ff;

endmodule

/* design/eoo_checker.sv */
module eoo_checker #(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_onset_seen,
   input logic                         rsp_offset_seen,
   input logic [SAMPLE_BITS+1:0]       rsp_threshold_level,
   input logic [SAMPLE_BITS-1:0]       rsp_mean_level,
   input logic                         rsp_buffer_end
);

   // a taken sample keeps the input busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not busy after a sample was taken");

   // no result can be finished in the cycle after a sample is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared right after a sample was taken");

   // a buffer latches at most one kind of event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_onset_seen && rsp_offset_seen))
      else $error("onset and offset latched together");

   // stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_threshold_level)
         && $stable(rsp_mean_level) && $stable(rsp_buffer_end)))
      else $error("stalled result beat changed");

endmodule

bind envelope_onset_offset_detector eoo_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_eoo_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_onset_seen      (rsp_onset_seen),
   .rsp_offset_seen     (rsp_offset_seen),
   .rsp_threshold_level (rsp_threshold_level),
   .rsp_mean_level      (rsp_mean_level),
   .rsp_buffer_end      (rsp_buffer_end)
);
